### rtl/core/acse_pkg.sv
// Shared types and constants of the AHCI command-slot engine.
package acse_pkg;

    // Port geometry and transfer limits.
    localparam int NumSlots     = 32;
    localparam int MaxEntries   = 8;
    localparam int ChunkBytes   = 4194304;
    localparam int SlotW        = 5;
    localparam int LenW         = 26;
    localparam int LbaW         = 48;
    localparam int SecW         = 17;
    localparam int BytesM1W     = 22;
    localparam int CountW       = 4;
    localparam int ChunkW       = $clog2(ChunkBytes) + 1;
    localparam int LimW         = LenW + 1;
    localparam logic [LimW-1:0] MaxLenBytes = LimW'(MaxEntries * ChunkBytes);
    localparam logic [SecW-1:0] MaxSectors  = SecW'(65536);

    // Task-file, interrupt status and FIS encodings.
    localparam logic [7:0]  TfBusyMask   = 8'h88;
    localparam int          TfesBit      = 30;
    localparam logic [7:0]  FisTypeH2d   = 8'h27;
    localparam logic [7:0]  FisCmdFlag   = 8'h80;
    localparam logic [7:0]  FisDevLba    = 8'h40;
    localparam logic [6:0]  HdrFlagsBase = 7'd5;
    localparam logic [6:0]  HdrFlagWrite = 7'd64;

    // Depth of the command queue between front and back.
    localparam int QDepth = 2;
    localparam int QAw    = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    typedef enum logic [1:0] {
        KIND_ENTRY = 2'd0,
        KIND_ISSUE = 2'd1,
        KIND_POLL  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_INVALID = 2'd1,
        STAT_NO_SLOT = 2'd2,
        STAT_BUSY    = 2'd3
    } t_stat;

    // What the front decided about one input word.
    typedef enum logic [1:0] {
        CLS_POLL   = 2'd0,
        CLS_REJECT = 2'd1,
        CLS_ISSUE  = 2'd2
    } t_cls;

    typedef struct packed {
        logic            mode;
        logic [31:0]     buf_addr;
        logic [LenW-1:0] len_bytes;
        logic [LbaW-1:0] lba;
        logic [SecW-1:0] sector_count;
        logic            write;
        logic [7:0]      ata_command;
        logic [7:0]      tfd_status;
        logic [31:0]     ci_bits;
        logic [31:0]     is_bits;
    } t_item;

    typedef struct packed {
        t_cls             cls;
        t_stat            status;
        logic [SlotW-1:0] slot;
        logic [31:0]      buf_addr;
        logic [LenW-1:0]  len_bytes;
        logic [LbaW-1:0]  lba;
        logic [SecW-1:0]  sector_count;
        logic             write;
        logic [7:0]       ata_command;
        logic [31:0]      done_mask;
    } t_cmd;

    typedef struct packed {
        t_kind              kind;
        t_stat              status;
        logic [SlotW-1:0]   slot;
        logic [31:0]        entry_addr;
        logic [BytesM1W-1:0] entry_bytes_minus_one;
        logic               entry_irq;
        logic [6:0]         header_flags;
        logic [CountW-1:0]  entry_count;
        logic [63:0]        fis_low;
        logic [63:0]        fis_high;
        logic [31:0]        done_mask;
        logic               last;
    } t_res;

endpackage

### rtl/core/acse_front.sv
// Front end: validates each input word, owns the slot map and claims or frees slots.
module acse_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  acse_pkg::t_item i_item,
    input  logic          i_q_full,
    output logic          o_q_push,
    output acse_pkg::t_cmd o_cmd
);
    import acse_pkg::*;

    logic [NumSlots-1:0] r_slot_busy;
    logic [NumSlots-1:0] n_slot_busy;
    logic [NumSlots-1:0] free_bits;
    logic [NumSlots-1:0] done_bits;
    logic [NumSlots-1:0] claim_bit;
    logic [SlotW-1:0]    low_slot;
    logic                invalid;
    logic                accept;

    assign accept   = i_push && !i_q_full;
    assign o_q_push = accept;

    assign free_bits = ~r_slot_busy;
    assign done_bits = r_slot_busy & ~i_item.ci_bits[NumSlots-1:0];

    // Lowest free slot.
    always_comb begin
        low_slot = '0;
        for (int i = NumSlots - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                low_slot = SlotW'(i);
            end
        end
    end

    assign claim_bit = NumSlots'(1) << low_slot;

    assign invalid = (i_item.buf_addr == '0) || (i_item.len_bytes == '0) ||
                     (i_item.sector_count == '0) ||
                     (i_item.sector_count > MaxSectors) ||
                     (LimW'(i_item.len_bytes) > MaxLenBytes);

    // Classification in priority order, and the matching slot map update.
    always_comb begin
        n_slot_busy        = r_slot_busy;
        o_cmd.cls          = CLS_REJECT;
        o_cmd.status       = STAT_OK;
        o_cmd.slot         = low_slot;
        o_cmd.buf_addr     = i_item.buf_addr;
        o_cmd.len_bytes    = i_item.len_bytes;
        o_cmd.lba          = i_item.lba;
        o_cmd.sector_count = i_item.sector_count;
        o_cmd.write        = i_item.write;
        o_cmd.ata_command  = i_item.ata_command;
        o_cmd.done_mask    = 32'(done_bits);
        if (i_item.mode) begin
            o_cmd.cls   = CLS_POLL;
            o_cmd.status = ((done_bits != '0) && i_item.is_bits[TfesBit]) ?
                           STAT_BUSY : STAT_OK;
            n_slot_busy = r_slot_busy & ~done_bits;
        end else if (invalid) begin
            o_cmd.status = STAT_INVALID;
        end else if (free_bits == '0) begin
            o_cmd.status = STAT_NO_SLOT;
        end else if ((i_item.tfd_status & TfBusyMask) != '0) begin
            o_cmd.status = STAT_BUSY;
        end else begin
            o_cmd.cls   = CLS_ISSUE;
            n_slot_busy = r_slot_busy | claim_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_busy <= '0;
        end else if (accept) begin
            r_slot_busy <= n_slot_busy;
        end
    end

endmodule

### rtl/core/acse_cmd_fifo.sv
// Short command queue between the front end and the result sequencer.
module acse_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  acse_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output acse_pkg::t_cmd o_cmd
);
    import acse_pkg::*;

    t_cmd             r_mem [QDepth];
    logic [QAw-1:0]   r_wr_ptr;
    logic [QAw-1:0]   r_rd_ptr;
    logic [QCntW-1:0] r_count;
    logic [QAw-1:0]   n_wr_ptr;
    logic [QAw-1:0]   n_rd_ptr;
    logic [QCntW-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == QCntW'(QDepth));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QAw'(QDepth - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QAw'(QDepth - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### rtl/core/acse_back.sv
// Back end: walks each command through its scatter entries and final result word.
module acse_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  acse_pkg::t_cmd i_cmd,
    output logic           o_q_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output acse_pkg::t_res o_res
);
    import acse_pkg::*;

    typedef enum logic [2:0] {
        BS_IDLE  = 3'b001,
        BS_ENTRY = 3'b010,
        BS_FINAL = 3'b100
    } t_bstate;

    t_bstate           r_state;
    t_bstate           n_state;
    t_cmd              r_cmd;
    logic [LenW-1:0]   r_left;
    logic [31:0]       r_addr;
    logic [CountW-1:0] r_cnt;
    logic              r_ov;
    logic              n_ov;
    t_res              r_res;
    t_res              n_res;
    logic              out_free;
    logic              tail;
    logic [ChunkW-1:0] chunk;
    logic              load;
    logic              emit;

    assign out_free = !r_ov || i_pop;
    assign o_empty  = !r_ov;
    assign o_res    = r_res;
    assign load     = (r_state == BS_IDLE) && !i_q_empty;
    assign o_q_pop  = load;

    // Size of the current scatter entry.
    assign tail  = (r_left <= LenW'(ChunkBytes));
    assign chunk = tail ? r_left[ChunkW-1:0] : ChunkW'(ChunkBytes);

    // Sequencer and next result word.
    always_comb begin
        n_state = r_state;
        emit    = 1'b0;
        n_res   = '0;
        unique case (r_state)
            BS_IDLE: begin
                if (load) begin
                    n_state = (i_cmd.cls == CLS_ISSUE) ? BS_ENTRY : BS_FINAL;
                end
            end
            BS_ENTRY: begin
                emit                        = out_free;
                n_res.kind                  = KIND_ENTRY;
                n_res.status                = STAT_OK;
                n_res.slot                  = r_cmd.slot;
                n_res.entry_addr            = r_addr;
                n_res.entry_bytes_minus_one = BytesM1W'(chunk - 1'b1);
                n_res.entry_irq             = tail;
                if (out_free && tail) begin
                    n_state = BS_FINAL;
                end
            end
            BS_FINAL: begin
                emit       = out_free;
                n_res.last = 1'b1;
                case (r_cmd.cls)
                    CLS_POLL: begin
                        n_res.kind      = KIND_POLL;
                        n_res.status    = r_cmd.status;
                        n_res.done_mask = r_cmd.done_mask;
                    end
                    CLS_ISSUE: begin
                        n_res.kind         = KIND_ISSUE;
                        n_res.status       = STAT_OK;
                        n_res.slot         = r_cmd.slot;
                        n_res.header_flags = HdrFlagsBase |
                                             (r_cmd.write ? HdrFlagWrite : 7'd0);
                        n_res.entry_count  = r_cnt;
                        n_res.fis_low      = {FisDevLba, r_cmd.lba[23:16],
                                              r_cmd.lba[15:8], r_cmd.lba[7:0],
                                              8'h00, r_cmd.ata_command,
                                              FisCmdFlag, FisTypeH2d};
                        n_res.fis_high     = {16'h0000, r_cmd.sector_count[15:8],
                                              r_cmd.sector_count[7:0], 8'h00,
                                              r_cmd.lba[47:40], r_cmd.lba[39:32],
                                              r_cmd.lba[31:24]};
                    end
                    default: begin
                        n_res.kind   = KIND_ISSUE;
                        n_res.status = r_cmd.status;
                    end
                endcase
                if (out_free) begin
                    n_state = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
        n_ov = emit ? 1'b1 : (i_pop ? 1'b0 : r_ov);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    // Command copy, walk counters and the output register.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd  <= i_cmd;
            r_left <= i_cmd.len_bytes;
            r_addr <= i_cmd.buf_addr;
            r_cnt  <= '0;
        end else if (emit && (r_state == BS_ENTRY)) begin
            r_left <= r_left - LenW'(chunk);
            r_addr <= r_addr + 32'(chunk);
            r_cnt  <= r_cnt + 1'b1;
        end
        if (emit) begin
            r_res <= n_res;
        end
    end

endmodule

### rtl/core/ahci_command_slot_engine.sv
// Top level of the AHCI command-slot engine for one port.
//
//  channel   handshake          words
//  input     push / full        one issue or poll request
//  result    empty / pop        scatter entry, descriptor, status or completion
//
// For an issue the result sequencer loads the command, then puts out one
// scatter entry word per entry and then the descriptor; a poll or a rejected
// issue is loaded and then answered with one status word. The sequencer puts
// out one result word per cycle while pop keeps the result register free; a
// two-deep command queue lets the front keep taking requests meanwhile. Reset
// empties both queues and frees every slot. A stalled pop holds the result
// register and, once the queue fills, raises full.
module ahci_command_slot_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_mode,
    input  logic [31:0] i_buf_addr,
    input  logic [25:0] i_len_bytes,
    input  logic [47:0] i_lba,
    input  logic [16:0] i_sector_count,
    input  logic        i_write,
    input  logic [7:0]  i_ata_command,
    input  logic [7:0]  i_tfd_status,
    input  logic [31:0] i_ci_bits,
    input  logic [31:0] i_is_bits,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic [1:0]  o_status,
    output logic [4:0]  o_slot,
    output logic [31:0] o_entry_addr,
    output logic [21:0] o_entry_bytes_minus_one,
    output logic        o_entry_irq,
    output logic [6:0]  o_header_flags,
    output logic [3:0]  o_entry_count,
    output logic [63:0] o_fis_low,
    output logic [63:0] o_fis_high,
    output logic [31:0] o_done_mask,
    output logic        o_last
);
    import acse_pkg::*;

    t_item item;
    t_cmd  front_cmd;
    t_cmd  head_cmd;
    t_res  res;
    logic  q_push;
    logic  q_full;
    logic  q_empty;
    logic  q_pop;

    // Gather the request fields into one word.
    always_comb begin
        item.mode         = i_mode;
        item.buf_addr     = i_buf_addr;
        item.len_bytes    = i_len_bytes;
        item.lba          = i_lba;
        item.sector_count = i_sector_count;
        item.write        = i_write;
        item.ata_command  = i_ata_command;
        item.tfd_status   = i_tfd_status;
        item.ci_bits      = i_ci_bits;
        item.is_bits      = i_is_bits;
    end

    assign full = q_full;

    acse_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (item),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_cmd    (front_cmd)
    );

    acse_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    acse_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_cmd     (head_cmd),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_res     (res)
    );

    // Split the result word onto its ports.
    assign o_kind                  = res.kind;
    assign o_status                = res.status;
    assign o_slot                  = res.slot;
    assign o_entry_addr            = res.entry_addr;
    assign o_entry_bytes_minus_one = res.entry_bytes_minus_one;
    assign o_entry_irq             = res.entry_irq;
    assign o_header_flags          = res.header_flags;
    assign o_entry_count           = res.entry_count;
    assign o_fis_low               = res.fis_low;
    assign o_fis_high              = res.fis_high;
    assign o_done_mask             = res.done_mask;
    assign o_last                  = res.last;

    // A completion report always closes its request.
    a_poll_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_POLL) |-> o_last)
        else $error("poll result without last");

    // Scatter entries are never the final word and carry no status.
    a_entry_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_ENTRY) |-> (!o_last && o_status == STAT_OK))
        else $error("scatter entry marked last or with status");

    // A successful descriptor follows at least one scatter entry.
    a_desc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_ISSUE && o_status == STAT_OK) |->
        (o_last && o_entry_count != 4'd0))
        else $error("descriptor without scatter entries");

endmodule
